>>> rtl/tbht_pkg.sv
`timescale 1ns / 1ps
package tbht_pkg;

  // item opcodes carried in the mode field
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_TOUCH   = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic KIND_DOWN = 1'b0;
  localparam logic KIND_UP   = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] x;
    logic [7:0] y;
    logic [8:0] width;
    logic [7:0] height;
    logic [7:0] region_id;
  } tbht_in_t;

  typedef struct packed {
    logic [7:0] button_id;
    logic       event_kind;
  } tbht_out_t;

  // packet walking down the cell row
  typedef struct packed {
    logic [1:0] op;
    logic [8:0] px;      // left edge on add, point x on touch
    logic [7:0] py;      // top edge on add, point y on touch
    logic [9:0] right;   // inclusive right edge (add)
    logic [8:0] bottom;  // inclusive bottom edge (add)
    logic [7:0] rid;     // id to store (add) or id found (touch, release)
    logic       hit;     // a region already claimed this touch
  } tbht_pkt_t;

endpackage

>>> rtl/tbht_cell.sv
`timescale 1ns / 1ps
module tbht_cell #(
  parameter int unsigned MAX_REGIONS = 8,
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  parameter int unsigned CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tbht_pkg::tbht_pkt_t  pkt_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic                 valid_o,
  output tbht_pkg::tbht_pkt_t  pkt_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [CNT_W-1:0]     cnt_o
);
  import tbht_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MyPos = CNT_W'(CELL_IDX);

  logic [8:0] left_q;
  logic [7:0] top_q;
  logic [9:0] right_q;
  logic [8:0] bottom_q;
  logic [7:0] id_q;

  logic       sel;
  logic       in_table;
  logic       pt_in_rect;
  logic       wr_en;
  tbht_pkt_t  pkt_d;
  logic [IDX_W-1:0] idx_d;

  assign sel        = (idx_i == MyIdx);
  assign in_table   = (MyPos < cnt_i);
  assign pt_in_rect = (pkt_i.px >= left_q) && ({1'b0, pkt_i.px} <= right_q) &&
                      (pkt_i.py >= top_q) && ({1'b0, pkt_i.py} <= bottom_q);
  assign wr_en      = valid_i && (pkt_i.op == MODE_ADD) && sel;

  always_comb begin
    pkt_d = pkt_i;
    idx_d = idx_i;
    case (pkt_i.op)
      MODE_TOUCH: begin
        if (!pkt_i.hit && in_table && pt_in_rect) begin
          pkt_d.hit = 1'b1;
          pkt_d.rid = id_q;
          idx_d     = MyIdx;
        end
      end
      MODE_RELEASE: begin
        if (sel) begin
          pkt_d.rid = id_q;
        end
      end
      default: ;
    endcase
  end

  // stored region; zero after reset so a release before any add reports id 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      id_q     <= '0;
    end else if (wr_en) begin
      left_q   <= pkt_i.px;
      top_q    <= pkt_i.py;
      right_q  <= pkt_i.right;
      bottom_q <= pkt_i.bottom;
      id_q     <= pkt_i.rid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_o <= pkt_d;
    idx_o <= idx_d;
    cnt_o <= cnt_i;
  end

endmodule

>>> rtl/touch_button_hit_table.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  -----------------------------
// item      in         start & !busy             item_i  (tbht_pkg::tbht_in_t)
// result    out        res_valid_o, one cycle    res_o   (tbht_pkg::tbht_out_t)
//
// Clear items and dropped adds (table full) finish at accept; busy stays low.
// Add, touch and release items walk the cell row, one cell per cycle, from the
// inject register through every cell to the registered result; busy is high while
// such an item is in the row; one item at a time.
// Reset (rst_ni low, async) clears the table, the count and the active entry.
// The receiver cannot stall: a result is presented for one cycle only.
module touch_button_hit_table #(
  parameter int unsigned MAX_REGIONS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tbht_pkg::tbht_in_t   item_i,
  output logic                 res_valid_o,
  output tbht_pkg::tbht_out_t  res_o
);
  import tbht_pkg::*;

  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_REGIONS);

  // table bookkeeping
  logic [CNT_W-1:0] cnt_q, cnt_d;       // stored regions
  logic [IDX_W-1:0] active_q, active_d; // entry of last successful touch
  logic             busy_q, busy_d;

  // row taps: index 0 is the inject register, index k the output of cell k-1
  logic             row_v   [MAX_REGIONS+1];
  tbht_pkt_t        row_pkt [MAX_REGIONS+1];
  logic [IDX_W-1:0] row_idx [MAX_REGIONS+1];
  logic [CNT_W-1:0] row_cnt [MAX_REGIONS+1];

  logic             accept;
  logic             inject;
  logic             tail_v;
  tbht_pkt_t        tail_pkt;
  logic             res_fire;

  tbht_pkt_t        inj_pkt_d;
  logic [IDX_W-1:0] inj_idx_d;
  logic             inj_v_q;
  tbht_pkt_t        inj_pkt_q;
  logic [IDX_W-1:0] inj_idx_q;
  logic [CNT_W-1:0] inj_cnt_q;

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // everything but a clear or a full-table add goes down the row
  always_comb begin
    inject = 1'b0;
    case (item_i.mode)
      MODE_CLEAR:   inject = 1'b0;
      MODE_ADD:     inject = accept && (cnt_q < CntMax);
      MODE_TOUCH:   inject = accept;
      MODE_RELEASE: inject = accept;
      default:      inject = 1'b0;
    endcase
  end

  // build the packet; add precomputes the inclusive far corner
  always_comb begin
    inj_pkt_d.op     = item_i.mode;
    inj_pkt_d.px     = item_i.x;
    inj_pkt_d.py     = item_i.y;
    inj_pkt_d.right  = {1'b0, item_i.x} + {1'b0, item_i.width};
    inj_pkt_d.bottom = {1'b0, item_i.y} + {1'b0, item_i.height};
    inj_pkt_d.rid    = item_i.region_id;
    inj_pkt_d.hit    = 1'b0;
    inj_idx_d        = (item_i.mode == MODE_ADD) ? cnt_q[IDX_W-1:0] : active_q;
  end

  assign tail_v   = row_v[MAX_REGIONS];
  assign tail_pkt = row_pkt[MAX_REGIONS];
  assign res_fire = tail_v && ((tail_pkt.op == MODE_RELEASE) ||
                               ((tail_pkt.op == MODE_TOUCH) && tail_pkt.hit));

  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    busy_d   = busy_q;
    if (accept && (item_i.mode == MODE_CLEAR)) begin
      cnt_d = '0;
    end else if (inject && (item_i.mode == MODE_ADD)) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (tail_v && (tail_pkt.op == MODE_TOUCH) && tail_pkt.hit) begin
      active_d = row_idx[MAX_REGIONS];
    end
    if (inject) begin
      busy_d = 1'b1;
    end else if (tail_v) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      active_q    <= '0;
      busy_q      <= 1'b0;
      inj_v_q     <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      busy_q      <= busy_d;
      inj_v_q     <= inject;
      res_valid_o <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    inj_pkt_q <= inj_pkt_d;
    inj_idx_q <= inj_idx_d;
    inj_cnt_q <= cnt_q;
    res_o.button_id  <= tail_pkt.rid;
    res_o.event_kind <= (tail_pkt.op == MODE_RELEASE) ? KIND_UP : KIND_DOWN;
  end

  assign row_v[0]   = inj_v_q;
  assign row_pkt[0] = inj_pkt_q;
  assign row_idx[0] = inj_idx_q;
  assign row_cnt[0] = inj_cnt_q;

  // one cell per region; the lowest matching cell claims a touch first
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    tbht_cell #(
      .MAX_REGIONS (MAX_REGIONS),
      .CELL_IDX    (g),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (row_v[g]),
      .pkt_i   (row_pkt[g]),
      .idx_i   (row_idx[g]),
      .cnt_i   (row_cnt[g]),
      .valid_o (row_v[g+1]),
      .pkt_o   (row_pkt[g+1]),
      .idx_o   (row_idx[g+1]),
      .cnt_o   (row_cnt[g+1])
    );
  end

  // a result only appears as the row drains
  a_res_at_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe without a draining item");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("region count past table size");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(active_q) < CntMax)
    else $error("active entry outside table");

  a_touch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.mode == MODE_TOUCH)) |=> busy)
    else $error("touch item did not enter the row");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for touch_button_hit_table.
// A shadow copy of the region table predicts each down/up event when an item
// is accepted. A free-running monitor compares every result strobe with the
// oldest prediction.
module tb;
  import tbht_pkg::*;

  localparam int MAX_REGIONS = 8;
  // covers the trip from accept through the inject register and every cell to the result strobe, with margin
  localparam int SETTLE_CYCLES = MAX_REGIONS + 6;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  tbht_in_t  item_i;
  logic      res_valid_o;
  tbht_out_t res_o;

  touch_button_hit_table #(
    .MAX_REGIONS(MAX_REGIONS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // ---------------------------------------------------------------------
  // Shadow table: edges, ids, fill level and the entry of the last hit
  // ---------------------------------------------------------------------
  logic [8:0] tbl_left   [MAX_REGIONS];
  logic [7:0] tbl_top    [MAX_REGIONS];
  logic [9:0] tbl_right  [MAX_REGIONS];
  logic [8:0] tbl_bottom [MAX_REGIONS];
  logic [7:0] tbl_id     [MAX_REGIONS];
  int unsigned tbl_count;
  int unsigned active_entry;

  tbht_out_t expected_events[$];
  tbht_out_t oldest_event;

  int errors;
  int cycle_count;
  int idle_pct;      // chance in a hundred that the sender skips a cycle
  int items_sent;
  int downs_seen;
  int ups_seen;
  int misses_seen;
  int adds_dropped;
  int clears_sent;

  // ---------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction: applied once per accepted item, in acceptance order
  // ---------------------------------------------------------------------
  task automatic update_hit_table(input tbht_in_t it);
    tbht_out_t ev;
    bit        found;
    found = 1'b0;
    case (it.mode)
      MODE_CLEAR: begin
        // only the fill level goes back; entries and active entry stay stale
        tbl_count = 0;
        clears_sent++;
      end
      MODE_ADD: begin
        if (tbl_count < MAX_REGIONS) begin
          tbl_left[tbl_count]   = it.x;
          tbl_top[tbl_count]    = it.y;
          tbl_right[tbl_count]  = {1'b0, it.x} + {1'b0, it.width};
          tbl_bottom[tbl_count] = {1'b0, it.y} + {1'b0, it.height};
          tbl_id[tbl_count]     = it.region_id;
          tbl_count++;
        end else begin
          adds_dropped++;
        end
      end
      MODE_TOUCH: begin
        // lowest entry wins; both corners count as inside
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (!found && i < tbl_count &&
              it.x >= tbl_left[i] && it.x <= tbl_right[i] &&
              it.y >= tbl_top[i] && it.y <= tbl_bottom[i]) begin
            found = 1'b1;
            active_entry = i;
            ev.button_id = tbl_id[i];
            ev.event_kind = KIND_DOWN;
          end
        end
        if (found) begin
          expected_events.push_back(ev);
          downs_seen++;
        end else begin
          misses_seen++;
        end
      end
      default: begin
        // release reports the active entry even if cleared or never touched
        ev.button_id = tbl_id[active_entry];
        ev.event_kind = KIND_UP;
        expected_events.push_back(ev);
        ups_seen++;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got id=%02h kind=%0b",
                 $time, res_o.button_id, res_o.event_kind);
      end else begin
        oldest_event = expected_events.pop_front();
        if (res_o.button_id !== oldest_event.button_id) begin
          errors++;
          $display("%0t: button_id mismatch, expected %02h, got %02h",
                   $time, oldest_event.button_id, res_o.button_id);
        end
        if (res_o.event_kind !== oldest_event.event_kind) begin
          errors++;
          $display("%0t: event_kind mismatch, expected %0b, got %0b",
                   $time, oldest_event.event_kind, res_o.event_kind);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving: change at negedge, accept seen at posedge with busy low
  // ---------------------------------------------------------------------
  task automatic send_item(input tbht_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    update_hit_table(it);
  endtask

  // Sender holds off until every event is out, then lets the scan settle
  task automatic wait_all_results();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic tbht_in_t mk_item(logic [1:0] mode, logic [8:0] x, logic [7:0] y,
                                       logic [8:0] w, logic [7:0] h, logic [7:0] rid);
    tbht_in_t it;
    it.mode = mode;
    it.x = x;
    it.y = y;
    it.width = w;
    it.height = h;
    it.region_id = rid;
    return it;
  endfunction

  // Mostly small regions and touches aimed at stored ones, plus noise.
  // Unused fields carry random junk so the block must ignore them.
  function automatic tbht_in_t random_item();
    tbht_in_t    it;
    int unsigned r;
    int unsigned k;
    int unsigned x_hi;
    int unsigned y_hi;
    it = mk_item(MODE_CLEAR, 9'($urandom_range(511)), 8'($urandom_range(255)),
                 9'($urandom_range(511)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 6) begin
      it.mode = MODE_CLEAR;
    end else if (r < 36) begin
      it.mode = MODE_ADD;
      if ($urandom_range(99) < 85) begin
        it.width = 9'($urandom_range(63));
        it.height = 8'($urandom_range(31));
      end
    end else if (r < 80) begin
      it.mode = MODE_TOUCH;
      if (tbl_count > 0 && $urandom_range(99) < 70) begin
        k = $urandom_range(tbl_count - 1);
        x_hi = (tbl_right[k] > 511) ? 511 : tbl_right[k];
        y_hi = (tbl_bottom[k] > 255) ? 255 : tbl_bottom[k];
        // corners now and then, otherwise anywhere inside
        case ($urandom_range(3))
          0: begin
            it.x = tbl_left[k];
            it.y = tbl_top[k];
          end
          1: begin
            it.x = 9'(x_hi);
            it.y = 8'(y_hi);
          end
          default: begin
            it.x = 9'($urandom_range(x_hi, tbl_left[k]));
            it.y = 8'($urandom_range(y_hi, tbl_top[k]));
          end
        endcase
      end
    end else begin
      it.mode = MODE_RELEASE;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_release_after_reset();
    // reset ids are zero; an empty table never hits
    send_item(mk_item(MODE_RELEASE, 9'd0, 8'd0, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_TOUCH, 9'd5, 8'd5, 9'd0, 8'd0, 8'd0));
  endtask

  task automatic test_inclusive_corners();
    // zero-size region at the origin holds exactly one point
    send_item(mk_item(MODE_ADD, 9'd0, 8'd0, 9'd0, 8'd0, 8'h11));
    send_item(mk_item(MODE_TOUCH, 9'd0, 8'd0, 9'd511, 8'd255, 8'hFF));
    send_item(mk_item(MODE_TOUCH, 9'd1, 8'd0, 9'd0, 8'd0, 8'd0));
    // widest region: right and bottom run past the coordinate range
    send_item(mk_item(MODE_ADD, 9'd511, 8'd255, 9'd511, 8'd255, 8'hFF));
    send_item(mk_item(MODE_TOUCH, 9'd511, 8'd255, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_RELEASE, 9'd511, 8'd255, 9'd511, 8'd255, 8'hFF));
  endtask

  task automatic test_first_match_wins();
    send_item(mk_item(MODE_ADD, 9'd100, 8'd50, 9'd20, 8'd10, 8'hA5));
    send_item(mk_item(MODE_ADD, 9'd110, 8'd55, 9'd50, 8'd50, 8'h5A));
    send_item(mk_item(MODE_TOUCH, 9'd115, 8'd58, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_TOUCH, 9'd120, 8'd60, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_TOUCH, 9'd121, 8'd60, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_RELEASE, 9'd0, 8'd0, 9'd0, 8'd0, 8'd0));
  endtask

  task automatic test_table_full();
    send_item(mk_item(MODE_ADD, 9'd200, 8'd0, 9'd10, 8'd5, 8'h01));
    send_item(mk_item(MODE_ADD, 9'd220, 8'd0, 9'd10, 8'd5, 8'h02));
    send_item(mk_item(MODE_ADD, 9'd240, 8'd0, 9'd10, 8'd5, 8'h04));
    send_item(mk_item(MODE_ADD, 9'd260, 8'd0, 9'd10, 8'd5, 8'h08));
    // ninth add is dropped, so its area stays dead
    send_item(mk_item(MODE_ADD, 9'd400, 8'd200, 9'd10, 8'd10, 8'h99));
    send_item(mk_item(MODE_TOUCH, 9'd405, 8'd205, 9'd0, 8'd0, 8'd0));
  endtask

  task automatic test_clear_keeps_stale();
    send_item(mk_item(MODE_CLEAR, 9'd511, 8'd255, 9'd511, 8'd255, 8'hFF));
    send_item(mk_item(MODE_TOUCH, 9'd511, 8'd255, 9'd0, 8'd0, 8'd0));
    // release after clear still reports the stale active id
    send_item(mk_item(MODE_RELEASE, 9'd0, 8'd0, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_ADD, 9'd0, 8'd0, 9'd511, 8'd255, 8'h3C));
    send_item(mk_item(MODE_TOUCH, 9'd300, 8'd100, 9'd0, 8'd0, 8'd0));
    send_item(mk_item(MODE_RELEASE, 9'd0, 8'd0, 9'd0, 8'd0, 8'd0));
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    idle_pct = pct;
    repeat (n_items) send_item(random_item());
    wait_all_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    errors = 0;
    idle_pct = 0;
    items_sent = 0;
    downs_seen = 0;
    ups_seen = 0;
    misses_seen = 0;
    adds_dropped = 0;
    clears_sent = 0;
    tbl_count = 0;
    active_entry = 0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      tbl_left[i] = '0;
      tbl_top[i] = '0;
      tbl_right[i] = '0;
      tbl_bottom[i] = '0;
      tbl_id[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_release_after_reset();
    test_inclusive_corners();
    test_first_match_wins();
    test_table_full();
    test_clear_keeps_stale();
    // full stop here: nothing new until the table has answered everything
    wait_all_results();

    // back to back, then a sparse sender, then a moderately busy one;
    // the result side has no backpressure to exercise
    test_random_traffic(0, 175);
    test_random_traffic(83, 175);
    test_random_traffic(32, 175);

    $display("Run covered %0d items (%0d clears, %0d adds dropped when full)",
             items_sent, clears_sent, adds_dropped);
    $display("  %0d button-down and %0d button-up events checked, %0d touches missed",
             downs_seen, ups_seen, misses_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
